// ----- hdl/adpac_pkg.sv -----
// Shared constants, register indexes and table generators for the audio drive chain.
package adpac_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 24;
    localparam int PHASE_W     = 32;
    localparam int LFO_W       = 24;
    localparam int GAIN_W      = 12;
    localparam int MAG_W       = 28;
    localparam int PROD_W      = MAG_W + LFO_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Fraction bits of the LFO and gain products.
    localparam int LFO_FRAC  = 23;
    localparam int GAIN_FRAC = 8;

    // Full scale and its largest positive code, as magnitudes.
    localparam logic [MAG_W-1:0] UNITY    = MAG_W'(1) << LFO_FRAC;
    localparam logic [MAG_W-1:0] UNITY_M1 = (MAG_W'(1) << LFO_FRAC) - MAG_W'(1);

    // Phase of channel one after reset: half a turn.
    localparam logic [PHASE_W-1:0] PULSE_PHASE_CH1_RESET = 32'h8000_0000;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_AM_ENABLE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AM_PHASE_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_ENABLE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_PHASE_STEP = 3'd5;

    // Drive modes.
    localparam logic [1:0] DRIVE_OFF       = 2'd0;
    localparam logic [1:0] DRIVE_SOFT      = 2'd1;
    localparam logic [1:0] DRIVE_HARD      = 2'd2;
    localparam logic [1:0] DRIVE_GAIN_ONLY = 2'd3;

    // Q30 constants for table generation.
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Restoring division, one quotient bit per loop pass; used only at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Cosine in Q30 on the first quadrant, Horner form of the Taylor series.
    function automatic logic [63:0] cos_quadrant(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd132;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd90;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
        p  = ((x2 * t) >> 30) / 64'd2;
        return (p >= ONE_Q30) ? 64'd0 : (ONE_Q30 - p);
    endfunction

    // Raised cosine entry k of a table with 2^bits entries, Q23.
    function automatic logic [LFO_W-1:0] raised_cos_entry(input logic [63:0] k, input int bits);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] sum;
        q = (k >> (bits - 2)) & 64'd3;
        r = k & ((64'd1 << (bits - 2)) - 64'd1);
        x = (r * HALF_PI_Q30) >> (bits - 2);
        if (q == 64'd0) begin
            sum = ONE_Q30 + cos_quadrant(x);
        end else if (q == 64'd1) begin
            sum = ONE_Q30 - cos_quadrant(HALF_PI_Q30 - x);
        end else if (q == 64'd2) begin
            sum = ONE_Q30 - cos_quadrant(x);
        end else begin
            sum = ONE_Q30 + cos_quadrant(HALF_PI_Q30 - x);
        end
        return LFO_W'((sum + 64'd128) >> 8);
    endfunction

    // Tanh entry k over [0,8] with 2^bits steps, Q23: series at x/128, then seven doublings.
    function automatic logic [LFO_W-1:0] tanh_entry(input logic [63:0] k, input int bits);
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] t2;
        v  = k << (33 - bits);
        a  = v >> 7;
        a2 = (a * a) >> 30;
        u  = ONE_Q30 - (64'd17 * a2) / 64'd42;
        u  = ONE_Q30 - (((64'd2 * a2) * u) >> 30) / 64'd5;
        u  = ONE_Q30 - ((a2 * u) >> 30) / 64'd3;
        t  = (a * u) >> 30;
        for (int i = 0; i < 7; i++) begin
            t2 = (t * t) >> 30;
            t  = udiv64(t << 31, ONE_Q30 + t2);
        end
        return LFO_W'((t + 64'd64) >> 7);
    endfunction

endpackage

// ----- hdl/am_drive_pulse_audio_chain.sv -----
// Top level of the tremolo, drive and pulse audio chain with one shared multiplier.
//
// Each input beat carries one Q1.23 sample and its channel; each output beat returns the
// processed sample for that channel. The sample magnitude passes through one 28x24-bit
// multiplier up to four times (tremolo, drive gain, tanh interpolation, pulse), each use
// having a multiply state and a rounding state, and soft drive adds a state that reads
// both neighboring entries of the tanh table. A channel beyond CHANNELS is echoed
// unchanged. The block takes no new sample until the current one is finished. A finished
// result waits in the output register, so the next sample is taken while it is
// unclaimed; the block stalls only when a second result is ready before the first is
// taken. Phases of each channel are kept in flip-flops; the pulse phase advances once
// per sample of its channel, the tremolo phase only while tremolo is enabled.
module am_drive_pulse_audio_chain #(
    parameter int CHANNELS        = 2,
    parameter int COS_TABLE_BITS  = 10,
    parameter int TANH_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] sample_in
    input  logic        s_tuser,    // [0] channel_index
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] sample_out
    output logic        m_tuser     // [0] channel_out
);

    localparam int SAMPLE_W  = adpac_pkg::SAMPLE_W;
    localparam int PHASE_W   = adpac_pkg::PHASE_W;
    localparam int LFO_W     = adpac_pkg::LFO_W;
    localparam int GAIN_W    = adpac_pkg::GAIN_W;
    localparam int MAG_W     = adpac_pkg::MAG_W;
    localparam int PROD_W    = adpac_pkg::PROD_W;
    localparam int LFO_FRAC  = adpac_pkg::LFO_FRAC;
    localparam int GAIN_FRAC = adpac_pkg::GAIN_FRAC;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COS_DEPTH  = 1 << COS_TABLE_BITS;
    localparam int TANH_DEPTH = (1 << TANH_TABLE_BITS) + 1;
    localparam int TANH_AW    = TANH_TABLE_BITS + 1;
    localparam int TANH_FB    = 26 - TANH_TABLE_BITS;
    localparam int TANH_K_W   = MAG_W - TANH_FB;

    localparam logic [TANH_K_W-1:0] TANH_LAST_K  = TANH_K_W'(1) << TANH_TABLE_BITS;
    localparam logic [TANH_AW-1:0]  TANH_LAST_A  = TANH_AW'(1) << TANH_TABLE_BITS;
    localparam logic [PROD_W:0]     PROD_ONE     = 1;
    localparam logic [PROD_W:0]     LFO_ROUND    = PROD_ONE << (LFO_FRAC - 1);
    localparam logic [PROD_W:0]     GAIN_ROUND   = PROD_ONE << (GAIN_FRAC - 1);
    localparam logic [PROD_W:0]     TANH_ROUND   = PROD_ONE << (TANH_FB - 1);

    // Constant tables, filled at elaboration.
    typedef logic [LFO_W-1:0] cos_rom_t [COS_DEPTH];
    typedef logic [LFO_W-1:0] tanh_rom_t [TANH_DEPTH];

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int k = 0; k < COS_DEPTH; k++) begin
            rom[k] = adpac_pkg::raised_cos_entry(64'(k), COS_TABLE_BITS);
        end
        return rom;
    endfunction

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t rom;
        for (int k = 0; k < TANH_DEPTH; k++) begin
            rom[k] = adpac_pkg::tanh_entry(64'(k), TANH_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam cos_rom_t  COS_ROM  = build_cos_rom();
    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

    typedef enum logic [3:0] {
        S_IDLE,
        S_AM_MUL,
        S_AM_RND,
        S_DRV_MUL,
        S_DRV_RND,
        S_TANH_RD,
        S_TANH_MUL,
        S_TANH_ADD,
        S_PUL_MUL,
        S_PUL_RND,
        S_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic                am_enable_reg;
    logic [PHASE_W-1:0]  am_phase_step_reg;
    logic [1:0]          drive_mode_reg;
    logic [GAIN_W-1:0]   drive_gain_reg;
    logic                pulse_enable_reg;
    logic [PHASE_W-1:0]  pulse_phase_step_reg;

    // Per-channel oscillator phases.
    logic [PHASE_W-1:0]  am_phase_reg    [CHANNELS];
    logic [PHASE_W-1:0]  pulse_phase_reg [CHANNELS];

    // Item being worked on.
    logic                ch_reg;
    logic [CH_IDX_W-1:0] ch_idx_reg;
    logic                echo_reg;
    logic                neg_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [TANH_FB-1:0]  frac_reg;
    logic [PROD_W-1:0]   prod_reg;

    // Table read data.
    logic [LFO_W-1:0]    cos_data_reg;
    logic [LFO_W-1:0]    tanh0_reg;
    logic [LFO_W-1:0]    tanh1_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [SAMPLE_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic                in_accept;
    logic                in_ch_ok;
    logic [CH_IDX_W-1:0] in_ch_idx;
    logic [SAMPLE_W-1:0] in_mag;
    logic [PHASE_W-1:0]  cos_phase;
    logic [COS_TABLE_BITS-1:0] cos_addr;
    logic [TANH_K_W-1:0] tanh_k;
    logic                tanh_sat;
    logic [TANH_AW-1:0]  tanh_addr0;
    logic [TANH_AW-1:0]  tanh_addr1;
    logic [LFO_W-1:0]    tanh_hi;
    logic [MAG_W-1:0]    mul_a;
    logic [LFO_W-1:0]    mul_b;
    logic [PROD_W:0]     lfo_sum;
    logic [PROD_W:0]     gain_sum;
    logic [PROD_W:0]     tanh_sum;
    logic [MAG_W-1:0]    lfo_round;
    logic [MAG_W-1:0]    gain_round;
    logic [LFO_W-1:0]    tanh_delta;
    logic [MAG_W-1:0]    neg_clip;
    logic [MAG_W-1:0]    neg_val;
    logic [MAG_W-1:0]    pos_clip;
    logic [SAMPLE_W-1:0] final_sample;
    logic                out_free;
    logic                out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_FIN) && out_free;

    // Channel decode and input magnitude.
    assign in_ch_ok  = (32'(s_tuser) < CHANNELS);
    assign in_ch_idx = in_ch_ok ? CH_IDX_W'(s_tuser) : '0;
    assign in_mag    = s_tdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - s_tdata) : s_tdata;

    // The cosine table reads the incoming channel's tremolo phase while idle and the
    // current channel's pulse phase afterwards.
    assign cos_phase = (state_reg == S_IDLE) ? am_phase_reg[in_ch_idx]
                                             : pulse_phase_reg[ch_idx_reg];
    assign cos_addr  = cos_phase[PHASE_W-1 -: COS_TABLE_BITS];

    // Tanh addresses of the two neighboring entries; at or beyond the last entry both
    // point at it.
    assign tanh_k     = mag_reg[MAG_W-1:TANH_FB];
    assign tanh_sat   = (tanh_k >= TANH_LAST_K);
    assign tanh_addr0 = tanh_sat ? TANH_LAST_A : tanh_k[TANH_AW-1:0];
    assign tanh_addr1 = tanh_sat ? TANH_LAST_A : (tanh_k[TANH_AW-1:0] + TANH_AW'(1));
    assign tanh_hi    = (tanh1_reg < tanh0_reg) ? tanh0_reg : tanh1_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_AM_MUL, S_PUL_MUL:
            begin
                mul_a = mag_reg;
                mul_b = cos_data_reg;
            end
            S_DRV_MUL:
            begin
                mul_a = mag_reg;
                mul_b = LFO_W'(drive_gain_reg);
            end
            S_TANH_MUL:
            begin
                mul_a = MAG_W'(frac_reg);
                mul_b = tanh_hi - tanh0_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the registered product.
    assign lfo_sum    = {1'b0, prod_reg} + LFO_ROUND;
    assign gain_sum   = {1'b0, prod_reg} + GAIN_ROUND;
    assign tanh_sum   = {1'b0, prod_reg} + TANH_ROUND;
    assign lfo_round  = lfo_sum[LFO_FRAC +: MAG_W];
    assign gain_round = gain_sum[GAIN_FRAC +: MAG_W];
    assign tanh_delta = tanh_sum[TANH_FB +: LFO_W];

    // Output saturation; negative full scale passes unchanged.
    assign neg_clip = (mag_reg > adpac_pkg::UNITY) ? adpac_pkg::UNITY : mag_reg;
    assign neg_val  = MAG_W'(0) - neg_clip;
    assign pos_clip = (mag_reg > adpac_pkg::UNITY_M1) ? adpac_pkg::UNITY_M1 : mag_reg;
    assign final_sample = echo_reg ? raw_reg
                        : (neg_reg ? neg_val[SAMPLE_W-1:0] : pos_clip[SAMPLE_W-1:0]);

    // Table reads, registered.
    always_ff @(posedge clk)
    begin
        cos_data_reg <= COS_ROM[cos_addr];
        tanh0_reg    <= TANH_ROM[tanh_addr0];
        tanh1_reg    <= TANH_ROM[tanh_addr1];
    end

    // Sequencer, configuration, phases, datapath and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            am_enable_reg        <= 1'b1;
            am_phase_step_reg    <= '0;
            drive_mode_reg       <= adpac_pkg::DRIVE_OFF;
            drive_gain_reg       <= 12'd1280;
            pulse_enable_reg     <= 1'b1;
            pulse_phase_step_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                am_phase_reg[c]    <= '0;
                pulse_phase_reg[c] <= (c == 1) ? adpac_pkg::PULSE_PHASE_CH1_RESET : '0;
            end
            ch_reg       <= 1'b0;
            ch_idx_reg   <= '0;
            echo_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            raw_reg      <= '0;
            mag_reg      <= '0;
            frac_reg     <= '0;
            prod_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            // Configuration writes; unknown indexes are ignored.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    adpac_pkg::REG_AM_ENABLE:        am_enable_reg        <= cfg_data[0];
                    adpac_pkg::REG_AM_PHASE_STEP:    am_phase_step_reg    <= cfg_data;
                    adpac_pkg::REG_DRIVE_MODE:       drive_mode_reg       <= cfg_data[1:0];
                    adpac_pkg::REG_DRIVE_GAIN:       drive_gain_reg       <= cfg_data[GAIN_W-1:0];
                    adpac_pkg::REG_PULSE_ENABLE:     pulse_enable_reg     <= cfg_data[0];
                    adpac_pkg::REG_PULSE_PHASE_STEP: pulse_phase_step_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // The shared multiplier, registered every cycle.
            prod_reg <= mul_a * mul_b;

            // A waiting result leaves when the sink takes it; a finished one takes its place.
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        ch_reg     <= s_tuser;
                        ch_idx_reg <= in_ch_idx;
                        echo_reg   <= !in_ch_ok;
                        neg_reg    <= s_tdata[SAMPLE_W-1];
                        raw_reg    <= s_tdata;
                        mag_reg    <= MAG_W'(in_mag);
                        state_reg  <= in_ch_ok ? S_AM_MUL : S_FIN;
                    end
                end
                S_AM_MUL:
                begin
                    if (am_enable_reg)
                    begin
                        am_phase_reg[ch_idx_reg] <= am_phase_reg[ch_idx_reg] + am_phase_step_reg;
                        state_reg <= S_AM_RND;
                    end
                    else
                    begin
                        state_reg <= (drive_mode_reg == adpac_pkg::DRIVE_OFF) ? S_PUL_MUL
                                                                             : S_DRV_MUL;
                    end
                end
                S_AM_RND:
                begin
                    mag_reg   <= lfo_round;
                    state_reg <= (drive_mode_reg == adpac_pkg::DRIVE_OFF) ? S_PUL_MUL
                                                                         : S_DRV_MUL;
                end
                S_DRV_MUL:
                begin
                    state_reg <= S_DRV_RND;
                end
                S_DRV_RND:
                begin
                    unique case (drive_mode_reg)
                        adpac_pkg::DRIVE_SOFT:
                        begin
                            mag_reg   <= gain_round;
                            state_reg <= S_TANH_RD;
                        end
                        adpac_pkg::DRIVE_HARD:
                        begin
                            mag_reg   <= (gain_round > adpac_pkg::UNITY) ? adpac_pkg::UNITY
                                                                          : gain_round;
                            state_reg <= S_PUL_MUL;
                        end
                        adpac_pkg::DRIVE_GAIN_ONLY:
                        begin
                            mag_reg   <= gain_round;
                            state_reg <= S_PUL_MUL;
                        end
                        adpac_pkg::DRIVE_OFF:
                        begin
                            state_reg <= S_PUL_MUL;
                        end
                    endcase
                end
                S_TANH_RD:
                begin
                    // Both table entries are read at this edge.
                    frac_reg  <= tanh_sat ? '0 : mag_reg[TANH_FB-1:0];
                    state_reg <= S_TANH_MUL;
                end
                S_TANH_MUL:
                begin
                    mag_reg   <= MAG_W'(tanh0_reg);
                    state_reg <= S_TANH_ADD;
                end
                S_TANH_ADD:
                begin
                    mag_reg   <= mag_reg + MAG_W'(tanh_delta);
                    state_reg <= S_PUL_MUL;
                end
                S_PUL_MUL:
                begin
                    // The pulse phase advances whether or not the pulse is applied.
                    pulse_phase_reg[ch_idx_reg] <= pulse_phase_reg[ch_idx_reg]
                                                 + pulse_phase_step_reg;
                    state_reg <= pulse_enable_reg ? S_PUL_RND : S_FIN;
                end
                S_PUL_RND:
                begin
                    mag_reg   <= lfo_round;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= final_sample;
                        m_tuser_reg  <= ch_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- test/audio_chain_checker.sv -----
`timescale 1ns / 100ps
// Checker for the audio chain: follows register writes, predicts every sample and compares.
module audio_chain_checker #(
    parameter int CHANNELS        = 2,
    parameter int COS_TABLE_BITS  = 10,
    parameter int TANH_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] sample_in
    input  logic        s_tuser,    // [0] channel_index
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [23:0] sample_out
    input  logic        m_tuser,    // [0] channel_out
    output int          mismatches,
    output int          pending,
    output int          results_checked
);

    localparam int          SAMPLE_W   = adpac_pkg::SAMPLE_W;
    localparam int          PHASE_W    = adpac_pkg::PHASE_W;
    localparam int          LFO_W      = adpac_pkg::LFO_W;
    localparam int          GAIN_W     = adpac_pkg::GAIN_W;
    localparam logic [63:0] ONE_Q30    = adpac_pkg::ONE_Q30;
    localparam logic [63:0] HALF_PI_Q30 = adpac_pkg::HALF_PI_Q30;
    localparam logic [63:0] FULL_SCALE = 64'd1 << 23;
    localparam logic [63:0] SIGN_SPAN  = 64'd1 << 24;
    localparam int          TANH_FRAC  = 26 - TANH_TABLE_BITS;

    typedef struct packed {
        logic                ch;
        logic [SAMPLE_W-1:0] smp;
    } chain_beat_t;

    // Samples predicted for beats that have been taken but not yet returned.
    chain_beat_t predicted_beats [$];

    // Local copy of the register file.
    logic              trem_on;
    logic [31:0]       trem_step;
    logic [1:0]        drive_sel;
    logic [GAIN_W-1:0] gain_q48;
    logic              pulse_on;
    logic [31:0]       pulse_inc;

    // Per-channel LFO phases.
    logic [PHASE_W-1:0] trem_angle  [CHANNELS];
    logic [PHASE_W-1:0] pulse_angle [CHANNELS];

    // Lookup tables, built once at time zero.
    logic [LFO_W-1:0] rcos_q23 [2**COS_TABLE_BITS];
    logic [LFO_W-1:0] tanh_q23 [2**TANH_TABLE_BITS + 1];

    // Cosine on the first quadrant in Q30, evaluated as a nested Taylor polynomial.
    function automatic logic [63:0] series_cos(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] half;
        sq  = (ang * ang) >> 30;
        acc = ONE_Q30;
        for (int n = 6; n >= 2; n--)
        begin
            acc = ONE_Q30 - ((sq * acc) >> 30) / 64'(2 * n * (2 * n - 1));
        end
        half = ((sq * acc) >> 30) / 64'd2;
        return (half >= ONE_Q30) ? 64'd0 : (ONE_Q30 - half);
    endfunction

    // Raised cosine (1+cos)/2 for table slot k, in Q23.
    function automatic logic [LFO_W-1:0] rcos_value(input logic [63:0] k);
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] ang;
        logic [63:0] sum;
        quad = k >> (COS_TABLE_BITS - 2);
        rem  = k & ((64'd1 << (COS_TABLE_BITS - 2)) - 64'd1);
        ang  = (rem * HALF_PI_Q30) >> (COS_TABLE_BITS - 2);
        case (quad)
            64'd0:   sum = ONE_Q30 + series_cos(ang);
            64'd1:   sum = ONE_Q30 - series_cos(HALF_PI_Q30 - ang);
            64'd2:   sum = ONE_Q30 - series_cos(ang);
            default: sum = ONE_Q30 + series_cos(HALF_PI_Q30 - ang);
        endcase
        return LFO_W'((sum + 64'd128) >> 8);
    endfunction

    // Tanh for table slot k over [0,8]: series at x/128, then seven angle doublings.
    function automatic logic [LFO_W-1:0] tanh_value(input logic [63:0] k);
        logic [63:0] x_small;
        logic [63:0] sq;
        logic [63:0] poly;
        logic [63:0] th;
        x_small = (k << (33 - TANH_TABLE_BITS)) >> 7;
        sq      = (x_small * x_small) >> 30;
        poly    = ONE_Q30 - (64'd17 * sq) / 64'd42;
        poly    = ONE_Q30 - (((64'd2 * sq) * poly) >> 30) / 64'd5;
        poly    = ONE_Q30 - ((sq * poly) >> 30) / 64'd3;
        th      = (x_small * poly) >> 30;
        for (int i = 0; i < 7; i++)
        begin
            th = (th << 31) / (ONE_Q30 + ((th * th) >> 30));
        end
        return LFO_W'((th + 64'd64) >> 7);
    endfunction

    // Soft clip of a magnitude with four integer bits, interpolating between tanh slots.
    function automatic logic [63:0] shape_soft(input logic [63:0] mag);
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        idx = mag >> TANH_FRAC;
        if (idx >= (64'd1 << TANH_TABLE_BITS))
        begin
            lo = 64'(tanh_q23[2**TANH_TABLE_BITS]);
        end
        else
        begin
            frac = mag & ((64'd1 << TANH_FRAC) - 64'd1);
            hi   = 64'(tanh_q23[idx + 64'd1]);
            lo   = 64'(tanh_q23[idx]);
            if (hi < lo)
            begin
                hi = lo;
            end
            lo = lo + (((hi - lo) * frac + (64'd1 << (TANH_FRAC - 1))) >> TANH_FRAC);
        end
        return lo;
    endfunction

    // Runs one sample through tremolo, drive and pulse, advancing the channel phases.
    task automatic run_chain(input logic ch, input logic [SAMPLE_W-1:0] smp,
                             output logic [SAMPLE_W-1:0] res);
        logic        neg;
        logic [63:0] mag;
        neg = smp[SAMPLE_W-1];
        mag = neg ? (SIGN_SPAN - 64'(smp)) : 64'(smp);
        if (int'(ch) >= CHANNELS)
        begin
            res = smp;
        end
        else
        begin
            if (trem_on)
            begin
                mag = (mag * 64'(rcos_q23[trem_angle[ch] >> (PHASE_W - COS_TABLE_BITS)])
                       + (FULL_SCALE >> 1)) >> 23;
                trem_angle[ch] = trem_angle[ch] + trem_step;
            end
            if (drive_sel != adpac_pkg::DRIVE_OFF)
            begin
                mag = (mag * 64'(gain_q48) + 64'd128) >> 8;
                if (drive_sel == adpac_pkg::DRIVE_SOFT)
                begin
                    mag = shape_soft(mag);
                end
                else if (drive_sel == adpac_pkg::DRIVE_HARD && mag > FULL_SCALE)
                begin
                    mag = FULL_SCALE;
                end
            end
            if (pulse_on)
            begin
                mag = (mag * 64'(rcos_q23[pulse_angle[ch] >> (PHASE_W - COS_TABLE_BITS)])
                       + (FULL_SCALE >> 1)) >> 23;
            end
            pulse_angle[ch] = pulse_angle[ch] + pulse_inc;
            // Negative side may reach -1.0; positive side stops one code short.
            if (neg)
            begin
                if (mag > FULL_SCALE)
                begin
                    mag = FULL_SCALE;
                end
                res = SAMPLE_W'(SIGN_SPAN - mag);
            end
            else
            begin
                if (mag > FULL_SCALE - 64'd1)
                begin
                    mag = FULL_SCALE - 64'd1;
                end
                res = SAMPLE_W'(mag);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    initial
    begin
        for (int k = 0; k < 2**COS_TABLE_BITS; k++)
        begin
            rcos_q23[k] = rcos_value(64'(k));
        end
        for (int k = 0; k <= 2**TANH_TABLE_BITS; k++)
        begin
            tanh_q23[k] = tanh_value(64'(k));
        end
    end

    // Watch the register port and both streams.
    always @(posedge clk or negedge rst_n)
    begin : watch
        chain_beat_t want;
        if (!rst_n)
        begin
            trem_on   = 1'b1;
            trem_step = '0;
            drive_sel = adpac_pkg::DRIVE_OFF;
            gain_q48  = 12'd1280;
            pulse_on  = 1'b1;
            pulse_inc = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                trem_angle[c]  = '0;
                pulse_angle[c] = (c == 1) ? adpac_pkg::PULSE_PHASE_CH1_RESET : '0;
            end
            predicted_beats.delete();
            pending <= 0;
        end
        else
        begin
            // Register writes, masked to each register's width.
            if (cfg_we)
            begin
                case (cfg_index)
                    adpac_pkg::REG_AM_ENABLE:        trem_on   = cfg_data[0];
                    adpac_pkg::REG_AM_PHASE_STEP:    trem_step = cfg_data;
                    adpac_pkg::REG_DRIVE_MODE:       drive_sel = cfg_data[1:0];
                    adpac_pkg::REG_DRIVE_GAIN:       gain_q48  = cfg_data[GAIN_W-1:0];
                    adpac_pkg::REG_PULSE_ENABLE:     pulse_on  = cfg_data[0];
                    adpac_pkg::REG_PULSE_PHASE_STEP: pulse_inc = cfg_data;
                    default:                         ;
                endcase
            end
            // Output beats are matched before a new input is queued at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (predicted_beats.size() == 0)
                begin
                    report_mismatch($sformatf("output beat ch %0d data %06h with nothing pending",
                                              m_tuser, m_tdata));
                end
                else
                begin
                    want = predicted_beats.pop_front();
                    results_checked++;
                    if (m_tuser !== want.ch)
                    begin
                        report_mismatch($sformatf("channel %0d, expected %0d", m_tuser, want.ch));
                    end
                    if (m_tdata !== want.smp)
                    begin
                        report_mismatch($sformatf("sample %06h, expected %06h on ch %0d",
                                                  m_tdata, want.smp, want.ch));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want.ch = s_tuser;
                run_chain(s_tuser, s_tdata, want.smp);
                predicted_beats.push_back(want);
            end
            pending <= predicted_beats.size();
        end
    end

endmodule

// ----- test/tb_am_drive_pulse_audio_chain.sv -----
`timescale 1ns / 100ps
// Testbench top for the tremolo, drive and pulse audio chain: stimulus, back-pressure, verdict.
module tb_am_drive_pulse_audio_chain;

    localparam int         SAMPLE_W    = adpac_pkg::SAMPLE_W;
    localparam int         GAIN_W      = adpac_pkg::GAIN_W;
    localparam int         CFG_INDEX_W = adpac_pkg::CFG_INDEX_W;
    localparam int         CFG_DATA_W  = adpac_pkg::CFG_DATA_W;
    localparam logic [1:0] DRIVE_OFF       = adpac_pkg::DRIVE_OFF;
    localparam logic [1:0] DRIVE_SOFT      = adpac_pkg::DRIVE_SOFT;
    localparam logic [1:0] DRIVE_HARD      = adpac_pkg::DRIVE_HARD;
    localparam logic [1:0] DRIVE_GAIN_ONLY = adpac_pkg::DRIVE_GAIN_ONLY;

    // Indexes past the register file; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_NONE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE_7 = 3'd7;
    localparam int RANDOM_ITEMS = 1250;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic                   m_tuser;

    int         mismatches;
    int         pending;
    int         results_checked;
    bit         calm = 1'b0;
    int         items_sent = 0;
    int         settings_applied = 0;
    int         mode_items [4];
    logic [1:0] cur_mode = DRIVE_OFF;
    int         ready_run = 0;
    int         stall_run = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    am_drive_pulse_audio_chain u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    audio_chain_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Sample mix: full-scale corners, small magnitudes of either sign, and anything.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned         r;
        logic [SAMPLE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 5))
                0:       v = 24'h7F_FFFF;
                1:       v = 24'h80_0000;
                2:       v = 24'h00_0000;
                3:       v = 24'h00_0001;
                4:       v = 24'hFF_FFFF;
                default: v = 24'h80_0001;
            endcase
        end
        else if (r < 40)
        begin
            v = SAMPLE_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 1)
            begin
                v = -v;
            end
        end
        else
        begin
            v = SAMPLE_W'($urandom);
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 12'd0;
            1:       return 12'hFFF;
            2:       return 12'd256;
            3:       return GAIN_W'($urandom_range(200, 600));
            default: return GAIN_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Narrow registers sometimes get garbage above their width, which must be dropped.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        if ($urandom_range(0, 1) == 1)
        begin
            return value | ($urandom << width);
        end
        return value;
    endfunction

    // Called at a rising edge; leaves the write enable high for the caller to drop.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes the whole register file plus the two unused indexes.
    task automatic set_chain(input logic am_en, input logic [31:0] am_step,
                             input logic [1:0] mode, input logic [GAIN_W-1:0] gain,
                             input logic p_en, input logic [31:0] p_step);
        write_reg(adpac_pkg::REG_AM_ENABLE, with_junk(32'(am_en), 1));
        write_reg(adpac_pkg::REG_AM_PHASE_STEP, am_step);
        write_reg(adpac_pkg::REG_DRIVE_MODE, with_junk(32'(mode), 2));
        write_reg(adpac_pkg::REG_DRIVE_GAIN, with_junk(32'(gain), GAIN_W));
        write_reg(adpac_pkg::REG_PULSE_ENABLE, with_junk(32'(p_en), 1));
        write_reg(adpac_pkg::REG_PULSE_PHASE_STEP, p_step);
        write_reg(REG_NONE_6, $urandom);
        write_reg(REG_NONE_7, $urandom);
        cfg_we <= 1'b0;
        cur_mode = mode;
        settings_applied++;
    endtask

    // Offers one beat after a random gap and holds it until taken.
    task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        mode_items[cur_mode]++;
    endtask

    // Waits until every predicted sample has come back and the block has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // Output back-pressure: runs of ready broken by stalls of random length.
    always @(posedge clk)
    begin
        if (calm)
        begin
            m_tready <= 1'b1;
        end
        else if (ready_run > 0)
        begin
            m_tready <= 1'b1;
            ready_run = ready_run - 1;
        end
        else if (stall_run > 0)
        begin
            m_tready <= 1'b0;
            stall_run = stall_run - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_run = $urandom_range(0, 12);
            stall_run = pick_gap();
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] corner_samples [0:5];
        int                  phase_len;
        int                  phase_no;
        int                  target;

        corner_samples[0] = 24'h7F_FFFF;
        corner_samples[1] = 24'h80_0000;
        corner_samples[2] = 24'h00_0000;
        corner_samples[3] = 24'h00_0001;
        corner_samples[4] = 24'hFF_FFFF;
        corner_samples[5] = 24'h40_0000;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Register values after reset; channel one starts at half a pulse turn.
        for (int i = 0; i < 8; i++)
        begin
            send_sample(1'(i), corner_samples[i % 6]);
        end
        wait_drained();

        // Gain without clipping at maximum gain: positive saturation, minus one kept.
        set_chain(1'b0, 32'h0, DRIVE_GAIN_ONLY, 12'hFFF, 1'b0, 32'h0);
        send_sample(1'b0, 24'h7F_FFFF);
        send_sample(1'b1, 24'h80_0000);
        send_sample(1'b0, 24'h00_0001);
        send_sample(1'b1, 24'hFF_FFFF);
        wait_drained();

        // Everything bypassed: full scale passes through.
        set_chain(1'b0, 32'h0, DRIVE_OFF, 12'd0, 1'b0, 32'h0);
        send_sample(1'b0, 24'h80_0000);
        send_sample(1'b1, 24'h7F_FFFF);
        wait_drained();

        // Soft drive at maximum gain with both LFOs moving.
        set_chain(1'b1, 32'h4000_0000, DRIVE_SOFT, 12'hFFF, 1'b1, 32'h2000_0000);
        send_sample(1'b0, 24'h7F_FFFF);
        send_sample(1'b1, 24'h80_0000);
        send_sample(1'b0, 24'h00_0100);
        wait_drained();

        // Hard clip.
        set_chain(1'b1, 32'hC000_0000, DRIVE_HARD, 12'h200, 1'b1, 32'h1000_0000);
        send_sample(1'b1, 24'h7F_FFFF);
        send_sample(1'b0, 24'h80_0000);
        send_sample(1'b1, 24'h12_3456);
        wait_drained();

        // Random phases: all-maximum and all-minimum settings first, then random ones.
        phase_no = 0;
        target   = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if (phase_no == 0)
            begin
                set_chain(1'b1, 32'hFFFF_FFFF, DRIVE_SOFT, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
            end
            else if (phase_no == 1)
            begin
                set_chain(1'b0, 32'h0, DRIVE_OFF, 12'd0, 1'b0, 32'h0);
            end
            else
            begin
                set_chain($urandom_range(0, 3) != 0, pick_step(), 2'($urandom_range(0, 3)),
                          pick_gain(), $urandom_range(0, 3) != 0, pick_step());
            end
            // One phase runs with no idling on either side.
            calm      = (phase_no == 2);
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) send_sample(1'($urandom_range(0, 1)), pick_sample());
            wait_drained();
            calm = 1'b0;
            phase_no++;
        end

        $display("Covered %0d samples under %0d register settings, %0d results checked.",
                 items_sent, settings_applied, results_checked);
        $display("Samples per drive mode: off %0d, soft %0d, hard %0d, gain only %0d.",
                 mode_items[DRIVE_OFF], mode_items[DRIVE_SOFT], mode_items[DRIVE_HARD],
                 mode_items[DRIVE_GAIN_ONLY]);
        if (mismatches == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- am_drive_pulse_audio_chain.f -----
hdl/adpac_pkg.sv
hdl/am_drive_pulse_audio_chain.sv
test/audio_chain_checker.sv
test/tb_am_drive_pulse_audio_chain.sv
